// ===== hw/rtl/largest_empty_square_finder_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define LESF_ASSERT_SAME(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define LESF_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/lesf_pkg.sv =====
package lesf_pkg;

  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 11;
  localparam int SIDE_W  = 11;
  localparam int OUT_POS_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 11;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 32;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 2'd2;

  localparam logic [CHAR_W-1:0] OBSTACLE_RESET = 8'd111;
  localparam logic [CNT_W-1:0]  COUNT_RESET    = 11'd1;

  // One processed cell, handed from the line-store stage to the best tracker
  typedef struct packed {
    logic              valid;
    logic [SIDE_W-1:0] side;
    logic [CNT_W-1:0]  row;
    logic [CNT_W-1:0]  col;
    logic              last;
  } cell_result_t;

endpackage

// ===== hw/rtl/largest_empty_square_finder.sv =====
// Result path: the last cell of a grid passes the line-store read and side compute (s1), the
//   s2 register, then the best update into the output register, which raises m_axis_tvalid.
// Throughput: one cell per cycle; input stalls only when a grid ends while the previous
//   result still waits on m_axis.
// Reset (rst, synchronous): obstacle_char 111, row_count 1, column_count 1, scan at row 0,
//   column 0, best cleared. The line store is not cleared and needs no clearing pass.
`include "largest_empty_square_finder_macros.svh"

module largest_empty_square_finder #(
  parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lesf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // s_axis_tdata, low bit up: cell_char[7:0]
  input  logic [lesf_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // m_axis_tdata, low bit up: square_row[9:0], square_col[9:0], square_side[10:0], zero pad
  output logic [lesf_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

  import lesf_pkg::*;

  localparam int AW = $clog2(MAX_COLS);

  logic [CHAR_W-1:0] obstacle_char;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  rows_eff;
  logic [CNT_W-1:0]  cols_eff;

  logic [CNT_W-1:0]  col_pos;
  logic [CNT_W-1:0]  row_pos;
  logic              col_end;
  logic              row_end;

  logic              restart;
  logic              in_fire;
  logic              hold;

  logic              s1_valid;
  logic              s1_free;
  logic              s1_first_row;
  logic              s1_first_col;
  logic              s1_fwd;
  logic              s1_last;
  logic [CNT_W-1:0]  s1_row;
  logic [CNT_W-1:0]  s1_col;

  logic [SIDE_W-1:0] rdata;
  logic [SIDE_W-1:0] left_side;
  logic [SIDE_W-1:0] upleft_side;
  logic [SIDE_W-1:0] fwd_side;
  logic [SIDE_W-1:0] up;
  logic [SIDE_W-1:0] lf;
  logic [SIDE_W-1:0] ul;
  logic [SIDE_W-1:0] min_a;
  logic [SIDE_W-1:0] min_b;
  logic [SIDE_W-1:0] side;
  logic              s1_move;
  logic              border_free;

  cell_result_t      cell_res;

  assign restart       = cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS);
  assign s_axis_tready = !hold;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s1_move       = s1_valid && !hold;
  assign border_free   = s1_valid && s1_free && (s1_first_row || s1_first_col);

  always_comb begin
    if (row_count == '0) begin
      rows_eff = CNT_W'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count;
    end
    if (column_count == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(column_count) > MAX_COLS) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = column_count;
    end
    col_end = (col_pos == cols_eff - CNT_W'(1));
    row_end = (row_pos == rows_eff - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_char <= OBSTACLE_RESET;
      row_count     <= COUNT_RESET;
      column_count  <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBSTACLE: obstacle_char <= cfg_data[CHAR_W-1:0];
        REG_ROWS:     row_count     <= cfg_data;
        REG_COLS:     column_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Raster position of the next cell
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_fire) begin
      if (col_end) begin
        col_pos <= '0;
        row_pos <= row_end ? '0 : row_pos + CNT_W'(1);
      end else begin
        col_pos <= col_pos + CNT_W'(1);
      end
    end
  end

  lesf_ram #(
    .WIDTH(SIDE_W),
    .DEPTH(MAX_COLS)
  ) u_line (
    .clk  (clk),
    .we   (s1_move),
    .waddr(AW'(s1_col)),
    .wdata(side),
    .re   (in_fire),
    .raddr(AW'(col_pos)),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_free      <= (s_axis_tdata[CHAR_W-1:0] != obstacle_char);
      s1_first_row <= (row_pos == '0);
      s1_first_col <= (col_pos == '0);
      s1_last      <= col_end && row_end;
      s1_row       <= row_pos;
      s1_col       <= col_pos;
      // Same entry being written back this edge: the read returns stale data
      s1_fwd       <= s1_valid && (s1_col == col_pos);
    end
  end

  always_comb begin
    up    = s1_first_row ? '0 : (s1_fwd ? fwd_side : rdata);
    lf    = s1_first_col ? '0 : left_side;
    ul    = s1_first_col ? '0 : upleft_side;
    min_a = (up < lf) ? up : lf;
    min_b = (min_a < ul) ? min_a : ul;
    side  = s1_free ? min_b + SIDE_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      left_side   <= '0;
      upleft_side <= '0;
    end else if (s1_move) begin
      left_side   <= side;
      upleft_side <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      fwd_side <= side;
    end
  end

  always_comb begin
    cell_res.valid = s1_valid;
    cell_res.side  = side;
    cell_res.row   = s1_row;
    cell_res.col   = s1_col;
    cell_res.last  = s1_last;
  end

  lesf_best u_best (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .cell_res     (cell_res),
    .hold         (hold),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  `LESF_ASSERT_SAME(a_pos_range, 1'b1, col_pos < cols_eff && row_pos < rows_eff, "off grid")
  `LESF_ASSERT_SAME(a_fwd_one_col, s1_valid && s1_fwd, cols_eff == CNT_W'(1), "stray forward")
  `LESF_ASSERT_SAME(a_edge_side, border_free, side == SIDE_W'(1), "border side not one")

endmodule

// ===== hw/rtl/lesf_ram.sv =====
module lesf_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lesf_best.sv =====
`include "largest_empty_square_finder_macros.svh"

module lesf_best (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  lesf_pkg::cell_result_t         cell_res,
  output logic                           hold,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // m_axis_tdata, low bit up: square_row[9:0], square_col[9:0], square_side[10:0], zero pad
  output logic [lesf_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

  import lesf_pkg::*;

  logic              s2_valid;
  logic [SIDE_W-1:0] s2_side;
  logic [CNT_W-1:0]  s2_row;
  logic [CNT_W-1:0]  s2_col;
  logic              s2_last;

  logic [SIDE_W-1:0] best_side;
  logic [CNT_W-1:0]  best_top;
  logic [CNT_W-1:0]  best_left;
  logic [SIDE_W-1:0] best_side_next;
  logic [CNT_W-1:0]  best_top_next;
  logic [CNT_W-1:0]  best_left_next;

  logic [CNT_W-1:0]     cand_top;
  logic [CNT_W-1:0]     cand_left;
  logic                 better;
  logic                 take;
  logic                 mid_take;
  logic                 end_take;

  logic [OUT_POS_W-1:0] out_row;
  logic [OUT_POS_W-1:0] out_col;
  logic [SIDE_W-1:0]    out_side;

  // A grid end cannot leave while the previous result is still waiting
  assign hold = s2_valid && s2_last && m_axis_tvalid && !m_axis_tready;
  assign take = s2_valid && !hold;
  assign mid_take = take && !s2_last && !restart;
  assign end_take = take && s2_last && !restart;

  always_comb begin
    cand_top  = s2_row + CNT_W'(1) - CNT_W'(s2_side);
    cand_left = s2_col + CNT_W'(1) - CNT_W'(s2_side);
    better = (s2_side != '0) &&
             ((s2_side > best_side) ||
              ((s2_side == best_side) &&
               ((cand_top < best_top) ||
                ((cand_top == best_top) && (cand_left < best_left)))));
    best_side_next = best_side;
    best_top_next  = best_top;
    best_left_next = best_left;
    if (better) begin
      best_side_next = s2_side;
      best_top_next  = cand_top;
      best_left_next = cand_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid      <= 1'b0;
      best_side     <= '0;
      best_top      <= '0;
      best_left     <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (restart) begin
      s2_valid  <= 1'b0;
      best_side <= '0;
      best_top  <= '0;
      best_left <= '0;
    end else begin
      if (!hold) begin
        s2_valid <= cell_res.valid;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (take) begin
        if (s2_last) begin
          m_axis_tvalid <= 1'b1;
          best_side     <= '0;
          best_top      <= '0;
          best_left     <= '0;
        end else begin
          best_side <= best_side_next;
          best_top  <= best_top_next;
          best_left <= best_left_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s2_side <= cell_res.side;
      s2_row  <= cell_res.row;
      s2_col  <= cell_res.col;
      s2_last <= cell_res.last;
    end
    if (take && s2_last) begin
      out_row  <= best_top_next[OUT_POS_W-1:0];
      out_col  <= best_left_next[OUT_POS_W-1:0];
      out_side <= best_side_next;
    end
  end

  assign m_axis_tdata = {1'b0, out_side, out_col, out_row};

  `LESF_ASSERT_NEXT(a_best_grows, mid_take, best_side >= $past(best_side), "best shrank")
  `LESF_ASSERT_NEXT(a_best_clear, end_take, best_side == '0 && m_axis_tvalid, "end not cleared")
  `LESF_ASSERT_SAME(a_hold_only_end, hold, s2_valid && s2_last, "stray stall")

endmodule
